@@ rtl/core/two_class_queue_with_cancel_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the two-class queue
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef TWO_CLASS_QUEUE_WITH_CANCEL_MACROS_SVH
`define TWO_CLASS_QUEUE_WITH_CANCEL_MACROS_SVH

// Same-cycle check.
`define TCQ_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// Next-cycle implication.
`define TCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/core/tcq_pkg.sv @@
// ---------------------------------------------------------------------------
// tcq_pkg
// Sizes, codes and controller states of the two-class queue.
// ---------------------------------------------------------------------------
package tcq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int KEY_BITS    = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int ENT_W       = KEY_BITS + 1;

	localparam logic [1:0] ACT_ENQ     = 2'd0;
	localparam logic [1:0] ACT_CANCEL  = 2'd1;
	localparam logic [1:0] ACT_CALL    = 2'd2;
	localparam logic [1:0] ACT_IGNORED = 2'd3;

	localparam logic [2:0] STAT_ENQUEUED = 3'd0;
	localparam logic [2:0] STAT_FULL     = 3'd1;
	localparam logic [2:0] STAT_REMOVED  = 3'd2;
	localparam logic [2:0] STAT_NOTFOUND = 3'd3;
	localparam logic [2:0] STAT_SERVED   = 3'd4;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_SHRD,
		S_SHWR,
		S_FIN,
		S_EMIT
	} state_t;

endpackage

@@ rtl/core/two_class_queue_with_cancel.sv @@
// A full enqueue or a cancel on an empty queue goes straight to the report. A normal
// enqueue writes at the tail. A priority enqueue and a cancel hit scan the slots, then
// shift the entries one slot; a cancel miss reports after the scan. A call reads the
// head and shifts the slots behind it for each served entry. Throughput: one request
// at a time, and output stalls hold the report until it is taken.
// Reset: arst_n empties the queue; slot memory contents stay undefined.
// ---------------------------------------------------------------------------
// two_class_queue_with_cancel
// Ordered queue of keyed entries in priority and normal classes, with cancel.
// ---------------------------------------------------------------------------
module two_class_queue_with_cancel (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // [1:0] action, [17:2] entry_key, rest zero
	input  logic        s_tuser,   // [0] priority_class
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // [2:0] status, [18:3] served_key, rest zero
	output logic        m_tuser,   // [0] served_class
	output logic        m_tlast
);
	import tcq_pkg::*;

	// Slot memory port between sequencer and RAM; slot 0 is the queue head.
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [IDX_W-1:0] mem_raddr;
	logic [ENT_W-1:0] mem_rdata;

	// Sequencer: scan for the insert point or a key match, shift the entries
	// one slot per read and write pair, then update the occupancy and report.
	tcq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Hold key and class of every slot, class in the low bit.
	tcq_ram #(
		.DEPTH (QUEUE_DEPTH),
		.WIDTH (ENT_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

@@ rtl/core/tcq_ram.sv @@
// ---------------------------------------------------------------------------
// tcq_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tcq_ram #(
	parameter int DEPTH  = 16,
	parameter int WIDTH  = 17,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/core/tcq_ctrl.sv @@
// ---------------------------------------------------------------------------
// tcq_ctrl
// Request sequencer: scans, shifts and updates the slot memory, emits results.
// ---------------------------------------------------------------------------
module tcq_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [23:0]                  s_tdata,
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [23:0]                  m_tdata,
	output logic                         m_tuser,
	output logic                         m_tlast,
	output logic                         mem_we,
	output logic [tcq_pkg::IDX_W-1:0]    mem_waddr,
	output logic [tcq_pkg::ENT_W-1:0]    mem_wdata,
	output logic [tcq_pkg::IDX_W-1:0]    mem_raddr,
	input  logic [tcq_pkg::ENT_W-1:0]    mem_rdata
);
	import tcq_pkg::*;

	state_t               state_q, state_d;
	logic [1:0]           act_q;
	logic [KEY_BITS-1:0]  key_q;
	logic                 cls_q;
	logic [OCC_W-1:0]     occ_q;
	logic [IDX_W-1:0]     idx_q;
	logic [IDX_W-1:0]     pos_q;
	logic                 first_q;
	logic [2:0]           stat_q;
	logic [KEY_BITS-1:0]  srv_key_q;
	logic                 srv_cls_q;
	logic                 o_valid_q;
	logic [2:0]           o_stat_q;
	logic [15:0]          o_key_q;
	logic                 o_cls_q;
	logic                 o_last_q;

	logic [1:0]           in_act;
	logic [KEY_BITS-1:0]  in_key;
	logic                 accept;
	logic                 down;
	logic                 rd_cls;
	logic [KEY_BITS-1:0]  rd_key;
	logic                 match;
	logic [OCC_W-1:0]     idx_inc;
	logic                 last_scan;
	logic                 more;
	logic                 emit_ok;
	logic                 call_again;

	assign in_act    = s_tdata[1:0];
	assign in_key    = KEY_BITS'(s_tdata[17:2]);
	assign accept    = s_tvalid && s_tready;
	assign down      = (act_q != ACT_ENQ);
	assign rd_cls    = mem_rdata[0];
	assign rd_key    = mem_rdata[ENT_W-1:1];
	assign idx_inc   = OCC_W'(idx_q) + OCC_W'(1);
	assign last_scan = (idx_inc == occ_q);
	assign more      = down ? (idx_inc < occ_q) : (idx_q > pos_q);
	assign emit_ok   = !o_valid_q || m_tready;
	// a call serves a second entry if one is left after the first
	assign call_again = (act_q == ACT_CALL) && first_q && (occ_q != '0);

	always_comb begin
		case (act_q)
			ACT_ENQ:  match = !rd_cls;
			ACT_CALL: match = 1'b1;
			default:  match = (rd_key == key_q);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_act)
						ACT_ENQ: begin
							if (occ_q == OCC_W'(QUEUE_DEPTH)) state_d = S_EMIT;
							else if (s_tuser && occ_q != '0) state_d = S_RD;
							else state_d = S_SHRD;
						end
						ACT_CANCEL: state_d = (occ_q == '0) ? S_EMIT : S_RD;
						ACT_CALL:   state_d = (occ_q == '0) ? S_IDLE : S_RD;
						default:    state_d = S_IDLE;
					endcase
				end
			end
			S_RD: state_d = S_CHK;
			S_CHK: begin
				if (match) state_d = S_SHRD;
				else if (last_scan) state_d = (act_q == ACT_ENQ) ? S_SHRD : S_EMIT;
				else state_d = S_RD;
			end
			S_SHRD: state_d = more ? S_SHWR : S_FIN;
			S_SHWR: state_d = S_SHRD;
			S_FIN:  state_d = S_EMIT;
			S_EMIT: begin
				if (emit_ok) state_d = call_again ? S_RD : S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// memory and handshake outputs
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = mem_rdata;
		mem_raddr = idx_q;
		case (state_q)
			S_SHRD: mem_raddr = down ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
			S_SHWR: mem_we = 1'b1;
			S_FIN: begin
				mem_we    = (act_q == ACT_ENQ);
				mem_waddr = pos_q;
				mem_wdata = {key_q, cls_q};
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			occ_q     <= '0;
			o_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_FIN) begin
				occ_q <= (act_q == ACT_ENQ) ? occ_q + OCC_W'(1) : occ_q - OCC_W'(1);
			end
			if (state_q == S_EMIT && emit_ok) o_valid_q <= 1'b1;
			else if (m_tready) o_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					act_q   <= in_act;
					key_q   <= in_key;
					cls_q   <= s_tuser;
					first_q <= 1'b1;
					idx_q   <= '0;
					pos_q   <= IDX_W'(occ_q);
					stat_q  <= (in_act == ACT_ENQ) ? STAT_FULL : STAT_NOTFOUND;
					// normal entry or empty queue: insert at the tail
					if (in_act == ACT_ENQ && !(s_tuser && occ_q != '0)) begin
						idx_q <= IDX_W'(occ_q);
					end
				end
			end
			S_CHK: begin
				if (match) begin
					pos_q <= idx_q;
					if (!down) idx_q <= IDX_W'(occ_q);
					srv_key_q <= rd_key;
					srv_cls_q <= rd_cls;
				end else if (last_scan) begin
					pos_q <= IDX_W'(occ_q);
					idx_q <= IDX_W'(occ_q);
				end else begin
					idx_q <= idx_q + IDX_W'(1);
				end
			end
			S_SHWR: idx_q <= down ? idx_q + IDX_W'(1) : idx_q - IDX_W'(1);
			S_FIN: begin
				case (act_q)
					ACT_ENQ:  stat_q <= STAT_ENQUEUED;
					ACT_CALL: stat_q <= STAT_SERVED;
					default:  stat_q <= STAT_REMOVED;
				endcase
			end
			S_EMIT: begin
				if (emit_ok) begin
					o_stat_q <= stat_q;
					o_key_q  <= (act_q == ACT_CALL) ? 16'(srv_key_q) : 16'd0;
					o_cls_q  <= (act_q == ACT_CALL) ? srv_cls_q : 1'b0;
					o_last_q <= !call_again;
					first_q  <= 1'b0;
					idx_q    <= '0;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = o_valid_q;
	assign m_tdata  = {5'd0, o_key_q, o_stat_q};
	assign m_tuser  = o_cls_q;
	assign m_tlast  = o_last_q;

`include "two_class_queue_with_cancel_macros.svh"

	`TCQ_ASSERT(a_occ_max, occ_q <= OCC_W'(QUEUE_DEPTH), "occupancy above depth")
	`TCQ_ASSERT(a_mid_call_busy, !(m_tvalid && !m_tlast && state_q == S_IDLE), "call split")
	`TCQ_ASSERT_NEXT(a_enq_grow, state_q == S_FIN && act_q == ACT_ENQ, occ_q == $past(occ_q) + OCC_W'(1), "enqueue count")

endmodule
